### src/ubds_pkg.sv
// shared types and constants for the uart baud divisor search
// used by ubds_div and uart_baud_divisor_search; no dependencies
`default_nettype none

package ubds_pkg;

	// common width of the shared divider datapath
	localparam int DW = 40;
	localparam int CW = $clog2(DW + 1);

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_HIGH  = 2'd1;
	localparam logic [1:0] ST_NONE      = 2'd2;
	localparam logic [1:0] ST_TOLERANCE = 2'd3;

	localparam logic [9:0]  TOL_RESET   = 10'd20;
	localparam logic [15:0] ERR_TOO_HIGH = 16'd1000;

	typedef enum logic [3:0] {
		SQ_IDLE,
		SQ_CHECK,
		SQ_FD10,
		SQ_CAND,
		SQ_T10,
		SQ_T100,
		SQ_BQ,
		SQ_BS,
		SQ_NEXT,
		SQ_RN,
		SQ_RQ,
		SQ_RS,
		SQ_EMUL,
		SQ_ERR,
		SQ_FIN
	} seq_state_t;

	typedef struct packed {
		logic          start;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [DW-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

### src/ubds_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on ubds_pkg for widths and the request/response structs
`default_nettype none

module ubds_div
	import ubds_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DW:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	// trial subtract of the shifted remainder
	always_comb begin
		trial = {rem_q[DW-1:0], quo_q[DW-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dvs_q}) : trial;
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

### src/uart_baud_divisor_search.sv
// uart baud divisor search top level: sequencer around one shared divider
// depends on ubds_pkg and ubds_div
`default_nettype none

// Takes a clock frequency and a wanted baud rate and returns bsel, bscale and
// clk2x with the rate error in permille. Candidates are tried in order clk2x 1
// then 0, bscale -7 up to 7; each candidate runs up to four divisions on the
// shared 40-bit restoring divider, or only two when its numerator or denominator
// already rules it out. Setup does the range check and clock/10, and the final
// work divides for the rate, rounds it and divides for the error. A baud that is
// too high ends the item without any division. There are thirty candidates in
// all, and an item with no fit at all tries every one of them. One item is in
// work at a time; s_tready is high only while the sequencer is idle, and a
// finished result may wait in the output register while the next item runs.
module uart_baud_divisor_search
	import ubds_pkg::*;
#(
	parameter int DIVISOR_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // clock_hz[25:0], wanted_baud[47:26]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // divisor[12:0], scale_exp[16:13],
	                                    // double_speed[17], error_permille[33:18]
	output logic [1:0]       m_tuser,   // status[1:0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [9:0]  cfg_data   // tolerance_permille
);

	localparam int BW = DIVISOR_BITS + 1;
	localparam logic [DW-1:0] LIMIT = DW'((64'd1 << BW) - 64'd1);

	seq_state_t state_q, state_d;
	div_req_t   dreq;
	div_rsp_t   drsp;

	logic [9:0]        tol_q;
	logic [25:0]       freq_q;
	logic [21:0]       baud_q;
	logic              mode_q;
	logic signed [3:0] s_q;
	logic [DW-1:0]     fd10_q, t_q, t10_q;
	logic [BW-1:0]     bsel_q;
	logic signed [DW:0] diff_q;
	logic              res_valid_q;

	logic [12:0]       res_div_q;
	logic [3:0]        res_s_q;
	logic              res_ds_q;
	logic [15:0]       res_err_q;
	logic [1:0]        res_st_q;

	logic [12:0]       out_div_q;
	logic [3:0]        out_s_q;
	logic              out_ds_q;
	logic [15:0]       out_err_q;
	logic [1:0]        out_st_q;

	logic [2:0]        osc_sh;
	logic [2:0]        kneg;
	logic [2:0]        kpos;
	logic [DW-1:0]     t_new;
	logic [DW-1:0]     bnum;
	logic              bnum_neg;
	logic [DW-1:0]     rnum_base, rnum, rden;
	logic              err_neg;
	logic [DW-1:0]     err_mag;
	logic signed [15:0] err_sat;
	logic              fin_go;

	ubds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// candidate arithmetic
	always_comb begin
		osc_sh    = mode_q ? 3'd3 : 3'd4;
		kneg      = 3'(-s_q);
		kpos      = s_q[3] ? 3'd0 : s_q[2:0];
		t_new     = ((DW'(baud_q)) << osc_sh) << kpos;
		bnum_neg  = (fd10_q < t10_q);
		bnum      = s_q[3] ? ((fd10_q - t10_q) << kneg) : (fd10_q - t10_q);
		rnum_base = s_q[3] ? ((DW'(freq_q) >> osc_sh) << kneg) : (DW'(freq_q) >> kpos);
		rnum      = (rnum_base << 3) + (rnum_base << 1);
		rden      = s_q[3] ? (DW'(bsel_q) + (DW'(1) << kneg))
		                   : ((DW'(bsel_q) + DW'(1)) << osc_sh);
		err_neg   = diff_q[DW];
		err_mag   = DW'(diff_q[DW] ? -diff_q : diff_q) * DW'(1000);
		if (err_neg)
			err_sat = (drsp.quotient > DW'(32768)) ? -16'sd32768
			                                      : 16'(-drsp.quotient);
		else
			err_sat = (drsp.quotient > DW'(32767)) ? 16'sd32767 : 16'(drsp.quotient);
		fin_go    = !res_valid_q || m_tready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SQ_IDLE:  if (s_tvalid) state_d = SQ_CHECK;
			SQ_CHECK: state_d = (DW'(baud_q) > (DW'(freq_q) >> 4)) ? SQ_FIN : SQ_FD10;
			SQ_FD10:  if (drsp.done) state_d = SQ_CAND;
			SQ_CAND:  state_d = SQ_T10;
			SQ_T10:   if (drsp.done) state_d = SQ_T100;
			SQ_T100: begin
				if (drsp.done)
					state_d = (bnum_neg || drsp.quotient == '0) ? SQ_NEXT : SQ_BQ;
			end
			SQ_BQ:    if (drsp.done) state_d = SQ_BS;
			SQ_BS: begin
				if (drsp.done) state_d = (drsp.quotient < LIMIT) ? SQ_RN : SQ_NEXT;
			end
			SQ_NEXT: begin
				if (s_q != 4'sd7) state_d = SQ_CAND;
				else if (mode_q)  state_d = SQ_CAND;
				else              state_d = SQ_FIN;
			end
			SQ_RN:    state_d = SQ_RQ;
			SQ_RQ:    if (drsp.done) state_d = SQ_RS;
			SQ_RS:    if (drsp.done) state_d = SQ_EMUL;
			SQ_EMUL:  state_d = SQ_ERR;
			SQ_ERR:   if (drsp.done) state_d = SQ_FIN;
			SQ_FIN:   if (fin_go) state_d = SQ_IDLE;
			default:  state_d = SQ_IDLE;
		endcase
	end

	// divider requests and handshake outputs
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = DW'(10);
		s_tready      = 1'b0;
		unique case (state_q)
			SQ_IDLE:  s_tready = 1'b1;
			SQ_CHECK: begin
				dreq.start    = !(DW'(baud_q) > (DW'(freq_q) >> 4));
				dreq.dividend = DW'(freq_q);
			end
			SQ_CAND: begin
				dreq.start    = 1'b1;
				dreq.dividend = t_new;
			end
			SQ_T10: begin
				dreq.start    = drsp.done;
				dreq.dividend = t_q;
				dreq.divisor  = DW'(100);
			end
			SQ_T100: begin
				dreq.start    = drsp.done && !bnum_neg && drsp.quotient != '0;
				dreq.dividend = bnum;
				dreq.divisor  = drsp.quotient;
			end
			SQ_BQ, SQ_RQ: begin
				dreq.start    = drsp.done;
				dreq.dividend = drsp.quotient + DW'(5);
			end
			SQ_RN: begin
				dreq.start    = 1'b1;
				dreq.dividend = rnum;
				dreq.divisor  = rden;
			end
			SQ_EMUL: begin
				dreq.start    = 1'b1;
				dreq.dividend = err_mag;
				dreq.divisor  = DW'(baud_q);
			end
			default: ;
		endcase
	end

	// sequencer state and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			tol_q       <= TOL_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) tol_q <= cfg_data;
			if (state_q == SQ_FIN && fin_go) res_valid_q <= 1'b1;
			else if (m_tready)               res_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: begin
				freq_q <= s_tdata[25:0];
				baud_q <= s_tdata[47:26];
			end
			SQ_CHECK: begin
				mode_q    <= 1'b1;
				s_q       <= -4'sd7;
				res_div_q <= '0;
				res_s_q   <= '0;
				res_ds_q  <= 1'b0;
				res_err_q <= ERR_TOO_HIGH;
				res_st_q  <= ST_TOO_HIGH;
			end
			SQ_FD10: if (drsp.done) fd10_q <= drsp.quotient;
			SQ_CAND: t_q <= t_new;
			SQ_T10:  if (drsp.done) t10_q <= drsp.quotient;
			SQ_BS:   if (drsp.done) bsel_q <= drsp.quotient[BW-1:0];
			SQ_NEXT: begin
				if (s_q != 4'sd7) begin
					s_q <= s_q + 4'sd1;
				end else if (mode_q) begin
					mode_q <= 1'b0;
					s_q    <= -4'sd7;
				end else begin
					res_div_q <= '0;
					res_s_q   <= '0;
					res_ds_q  <= 1'b0;
					res_err_q <= '0;
					res_st_q  <= ST_NONE;
				end
			end
			SQ_RS: begin
				if (drsp.done)
					diff_q <= $signed({1'b0, drsp.quotient}) - $signed({19'd0, baud_q});
			end
			SQ_ERR: begin
				if (drsp.done) begin
					res_s_q   <= s_q;
					res_ds_q  <= mode_q;
					res_err_q <= err_sat;
					if (err_sat > $signed({6'd0, tol_q})) begin
						res_st_q  <= ST_TOLERANCE;
						res_div_q <= '0;
					end else begin
						res_st_q  <= ST_OK;
						res_div_q <= 13'(bsel_q);
					end
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == SQ_FIN && fin_go) begin
			out_div_q <= res_div_q;
			out_s_q   <= res_s_q;
			out_ds_q  <= res_ds_q;
			out_err_q <= res_err_q;
			out_st_q  <= res_st_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = res_valid_q;
	assign m_tdata   = {6'd0, out_err_q, out_ds_q, out_s_q, out_div_q};
	assign m_tuser   = out_st_q;

endmodule

`default_nettype wire

### tb/sv/uart_baud_divisor_search_test.sv
// testbench for uart_baud_divisor_search: directed table, then random divisor searches
// checked against a local predictor of the search; depends on ubds_pkg and the block
`default_nettype none

module uart_baud_divisor_search_test
	import ubds_pkg::*;
();

	localparam int DIVISOR_BITS = 12;
	localparam int IDLE_LIMIT   = 60000;
	localparam int HOLD_CYCLES  = 3000;
	localparam int DRAIN_CYCLES = 64;

	typedef struct {
		logic [12:0]        divisor;
		logic signed [3:0]  scale_exp;
		logic               double_speed;
		logic signed [15:0] error_permille;
		logic [1:0]         status;
	} baud_setting_t;

	typedef struct {
		logic [25:0]   clock_hz;
		logic [21:0]   wanted_baud;
		bit            typed;
		baud_setting_t setting;
	} search_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [9:0]  cfg_data;

	baud_setting_t pending_settings[$];
	logic [9:0]    tolerance;
	int            idle_pct;
	int            stall_pct;
	int            hold_request;
	int            errors;
	int            searches_sent;
	int            settings_seen;
	int            status_seen[4];
	int            quiet_cycles;

	uart_baud_divisor_search #(.DIVISOR_BITS(DIVISOR_BITS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// rounded divisor candidate for one mode and exponent, -1 when unusable
	function automatic longint bsel_for(longint f, longint b, int s, longint osc);
		longint num, den, t;
		if (s >= 0) begin
			t   = osc * b * (longint'(1) << s);
			num = f / 10 - t / 10;
			den = t / 100;
		end else begin
			num = (longint'(1) << (-s)) * (f / 10 - osc * b / 10);
			den = osc * b / 100;
		end
		if (num < 0 || den == 0)
			return -1;
		return (num / den + 5) / 10;
	endfunction

	// baud rate that a chosen setting really gives
	function automatic longint rate_for(longint f, longint bsel, int s, longint osc);
		longint num, den;
		if (s >= 0) begin
			num = f / (longint'(1) << s) * 10;
			den = osc * (bsel + 1);
		end else begin
			num = f / osc * (longint'(1) << (-s)) * 10;
			den = bsel + (longint'(1) << (-s));
		end
		if (den <= 0)
			return -1;
		return (num / den + 5) / 10;
	endfunction

	// full divisor search: clk2x first, exponents -7 up to 7
	function automatic baud_setting_t search_setting(logic [25:0] clock_hz,
			logic [21:0] wanted_baud, logic [9:0] tol);
		baud_setting_t r;
		longint f, b, limit, bsel, err;
		int s, mode;
		bit found;
		f     = clock_hz;
		b     = wanted_baud;
		limit = (longint'(1) << (DIVISOR_BITS + 1)) - 1;
		r     = '{divisor: '0, scale_exp: '0, double_speed: 1'b0,
			error_permille: '0, status: ST_OK};
		found = 1'b0;
		bsel  = -1;
		s     = 0;
		if (b > f / 16) begin
			r.error_permille = ERR_TOO_HIGH;
			r.status         = ST_TOO_HIGH;
			return r;
		end
		for (mode = 1; mode >= 0 && !found; mode--) begin
			for (s = -7; s < 8 && !found; s++) begin
				bsel = bsel_for(f, b, s, mode ? 8 : 16);
				if (bsel > -1 && bsel < limit)
					found = 1'b1;
			end
			if (found)
				break;
		end
		if (!found || b == 0) begin
			r.status = ST_NONE;
			return r;
		end
		// loop increments ran once past the hit
		s   = s - 1;
		err = 1000 * (rate_for(f, bsel, s, mode ? 8 : 16) - b) / b;
		if (err > 32767)
			err = 32767;
		if (err < -32768)
			err = -32768;
		r.status         = (err > longint'(tol)) ? ST_TOLERANCE : ST_OK;
		r.divisor        = (r.status == ST_OK) ? bsel[12:0] : 13'd0;
		r.scale_exp      = s[3:0];
		r.double_speed   = mode[0];
		r.error_permille = err[15:0];
		return r;
	endfunction

	// result check against the oldest pending setting
	always @(posedge clk) begin
		baud_setting_t want;
		if (arst_n && m_tvalid && m_tready) begin
			settings_seen++;
			status_seen[m_tuser]++;
			if (pending_settings.size() == 0) begin
				$error("result with no pending search: tdata %h tuser %0d", m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_settings.pop_front();
				if (m_tdata[12:0] !== want.divisor) begin
					$error("divisor: expected %0d, got %0d", want.divisor, m_tdata[12:0]);
					errors++;
				end
				if (m_tdata[16:13] !== want.scale_exp) begin
					$error("scale_exp: expected %0d, got %0d", want.scale_exp,
						$signed(m_tdata[16:13]));
					errors++;
				end
				if (m_tdata[17] !== want.double_speed) begin
					$error("double_speed: expected %0d, got %0d", want.double_speed,
						m_tdata[17]);
					errors++;
				end
				if (m_tdata[33:18] !== want.error_permille) begin
					$error("error_permille: expected %0d, got %0d", want.error_permille,
						$signed(m_tdata[33:18]));
					errors++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("uart_baud_divisor_search_test: done, errors");
			$finish;
		end
	end

	// receiver: random stalls plus a long hold-off each time one is requested
	initial begin
		int hold_left;
		int holds_taken;
		hold_left   = 0;
		holds_taken = 0;
		m_tready    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != holds_taken) begin
				hold_left   = HOLD_CYCLES;
				holds_taken = hold_request;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// offer one search; a random gap may follow
	task automatic send_search(logic [25:0] clock_hz, logic [21:0] wanted_baud,
			bit typed, baud_setting_t setting);
		s_tvalid <= 1'b1;
		s_tdata  <= {wanted_baud, clock_hz};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_settings.push_back(typed ? setting
			: search_setting(clock_hz, wanted_baud, tolerance));
		searches_sent++;
		if ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// wait until every result is in and the block is surely idle
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_settings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		tolerance = value;
	endtask

	// random search, mostly realistic clock and baud pairs
	task automatic random_search;
		logic [25:0] clock_hz;
		logic [21:0] wanted_baud;
		int pick;
		pick = $urandom_range(99);
		if (pick < 60) begin
			clock_hz    = 26'($urandom_range(67108863, 1000000));
			wanted_baud = 22'(clock_hz / (16 * $urandom_range(4000, 2)));
		end else if (pick < 75) begin
			clock_hz    = 26'($urandom_range(67108863, 1));
			wanted_baud = 22'($urandom_range(clock_hz / 16 > 0 ? clock_hz / 16 : 1, 0));
		end else if (pick < 90) begin
			clock_hz    = 26'($urandom);
			wanted_baud = 22'($urandom);
		end else begin
			clock_hz    = 26'($urandom_range(4095, 0));
			wanted_baud = 22'($urandom_range(255, 0));
		end
		send_search(clock_hz, wanted_baud, 1'b0, '{default: '0});
	endtask

	// stimulus
	initial begin
		baud_setting_t too_high;
		baud_setting_t no_fit;
		baud_setting_t unused;
		search_row_t   rows[16];
		logic [9:0]    tol_steps[4];
		int            idle_steps[4];
		int            stall_steps[4];

		too_high = '{divisor: '0, scale_exp: '0, double_speed: 1'b0,
			error_permille: ERR_TOO_HIGH, status: ST_TOO_HIGH};
		no_fit   = '{divisor: '0, scale_exp: '0, double_speed: 1'b0,
			error_permille: '0, status: ST_NONE};
		unused   = '{divisor: '0, scale_exp: '0, double_speed: 1'b0,
			error_permille: '0, status: ST_OK};
		rows = '{
			'{26'd16,       22'd2,       1'b1, too_high},  // baud just above clock/16
			'{26'd0,        22'd1,       1'b1, too_high},  // zero clock
			'{26'd1,        22'd1,       1'b1, too_high},  // smallest clock
			'{26'd32000000, 22'd0,       1'b1, no_fit},    // zero baud
			'{26'd0,        22'd0,       1'b1, no_fit},    // zero clock and baud
			'{26'h3FFFFFF,  22'd0,       1'b1, no_fit},
			'{26'h3FFFFFF,  22'h3FFFFF,  1'b0, unused},    // both at maximum
			'{26'h3FFFFFF,  22'd1,       1'b0, unused},    // slowest baud, fastest clock
			'{26'd16,       22'd1,       1'b0, unused},    // baud exactly clock/16
			'{26'd32000000, 22'd9600,    1'b0, unused},
			'{26'd2000000,  22'd115200,  1'b0, unused},    // large error
			'{26'd16000000, 22'd1000000, 1'b0, unused},
			'{26'd7372800,  22'd115200,  1'b0, unused},    // exact divisor
			'{26'd1000000,  22'd300,     1'b0, unused},
			'{26'd48000000, 22'd3000000, 1'b0, unused},
			'{26'd3333,     22'd7,       1'b0, unused}
		};
		tol_steps   = '{10'd0, 10'd1000, TOL_RESET, 10'd0};
		idle_steps  = '{0, 56, 0, 20};
		stall_steps = '{0, 0, 56, 20};

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		tolerance    = TOL_RESET;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_request = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at reset tolerance
		foreach (rows[i])
			send_search(rows[i].clock_hz, rows[i].wanted_baud, rows[i].typed,
				rows[i].setting);
		drain();

		// random phases, each with its own tolerance and idling mix
		for (int p = 0; p < 4; p++) begin
			write_tolerance(p == 3 ? 10'($urandom_range(1000, 1)) : tol_steps[p]);
			idle_pct  = idle_steps[p];
			stall_pct = stall_steps[p];
			if (p == 2) begin
				// long receiver hold while items keep coming
				hold_request++;
				repeat (4) random_search();
				drain();
			end
			repeat (68) random_search();
			drain();
		end

		$display("searches: %0d sent, %0d results; ok %0d, too high %0d, none %0d, tolerance %0d",
			searches_sent, settings_seen, status_seen[ST_OK], status_seen[ST_TOO_HIGH],
			status_seen[ST_NONE], status_seen[ST_TOLERANCE]);
		$display("tolerances 0, 1000, reset and random; idle and stall mixes with a long hold");
		if (errors == 0)
			$display("uart_baud_divisor_search_test: done, clean");
		else
			$display("uart_baud_divisor_search_test: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
src/ubds_pkg.sv
src/ubds_div.sv
src/uart_baud_divisor_search.sv
tb/sv/uart_baud_divisor_search_test.sv
